// File: rtl/etsc_pkg.sv
// ============================================================================
// Expression token scanner package
// Shared types and constants: request and result payloads, the per-byte
// result bundle, queue status and token kind codes.
// ============================================================================
`default_nettype none

package etsc_pkg;

    // Width of the internal byte offset counters.
    localparam int OFFSET_BITS = 32;
    // Width of the range fields on the result channel.
    localparam int RANGE_BITS = 32;
    // Most results that one source byte can cause.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_BITS = $clog2(MAX_RESULTS);
    // Depth of the bundle queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Token kind codes.
    localparam logic [3:0] TK_BAD     = 4'd0;
    localparam logic [3:0] TK_END     = 4'd1;
    localparam logic [3:0] TK_INT     = 4'd2;
    localparam logic [3:0] TK_PLUS    = 4'd3;
    localparam logic [3:0] TK_MINUS   = 4'd4;
    localparam logic [3:0] TK_MUL     = 4'd5;
    localparam logic [3:0] TK_DIV     = 4'd6;
    localparam logic [3:0] TK_OPEN    = 4'd7;
    localparam logic [3:0] TK_CLOSE   = 4'd8;
    localparam logic [3:0] TK_EQUALS  = 4'd9;
    localparam logic [3:0] TK_IDENT   = 4'd10;
    localparam logic [3:0] TK_TOO_BIG = 4'd11;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    // One source byte request.
    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
    } request_t;

    // One token result.
    typedef struct packed {
        logic [3:0]            kind_code;
        logic [RANGE_BITS-1:0] range_start;
        logic [RANGE_BITS-1:0] range_end;
        logic [63:0]           integer_value;
        logic [7:0]            symbol_char;
        logic [2:0]            bad_length;
        logic                  run_end;
    } result_t;

    // All results caused by one source byte, in order from slot 0.
    typedef struct packed {
        logic [RES_CNT_BITS-1:0]  count;
        result_t [MAX_RESULTS-1:0] slot;
    } bundle_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: rtl/expression_token_scanner_top.sv
// ============================================================================
// Expression token scanner
// Tokenizes a byte stream of arithmetic expressions into integer, identifier,
// symbol, bad character and end tokens.
// ============================================================================
// The scanner accepts one source byte per cycle whenever its four-entry
// bundle queue has room, and each byte costs constant work in the front
// stage. A byte causes zero to three tokens; tokens leave one per cycle
// through the output register while m_ready is high, so a stream sustains
// one byte per cycle as long as it averages at most one token per byte, and
// the first token of a byte is held in its queue entry, then in the output
// register. Raise final_byte on the last byte of a text: the open token is
// flushed, an end token follows, and offsets restart at zero for the next text.
`default_nettype none

module expression_token_scanner_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire etsc_pkg::request_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output etsc_pkg::result_t       m_data
);
    import etsc_pkg::*;

    q_status_t q_status;
    logic      push;
    bundle_t   push_bundle;
    logic      pop;
    bundle_t   head;

    // Front: byte intake and tokenizer state machine.
    etsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_status    (q_status),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // Queue of per-byte result bundles.
    etsc_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .q_status    (q_status)
    );

    // Back: result serializer and output register.
    etsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// File: rtl/etsc_front.sv
// ============================================================================
// Expression token scanner front end
// Accepts one source byte per cycle while the queue has room, runs the
// tokenizer state machine and pushes the byte's result bundle into the queue.
// ============================================================================
`default_nettype none

module etsc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire etsc_pkg::request_t  s_data,
    input  wire etsc_pkg::q_status_t q_status,
    output logic                     push,
    output etsc_pkg::bundle_t        push_bundle
);
    import etsc_pkg::*;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_INT   = 2'd1;
    localparam logic [1:0] ST_IDENT = 2'd2;
    localparam logic [1:0] ST_SKIP  = 2'd3;

    logic [1:0]  st_reg, st_next;
    offset_t     token_begin_reg, token_begin_next;
    offset_t     byte_offset_reg, byte_offset_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  skip_rem_reg, skip_rem_next;
    offset_t     bad_begin_reg, bad_begin_next;
    logic [2:0]  bad_count_reg, bad_count_next;

    logic                     accept;
    logic [7:0]               b;
    offset_t                  off;
    offset_t                  off_plus;
    logic                     b_digit, b_letter, b_space, b_cont;
    logic [3:0]               sym_kind;
    logic [2:0]               lead_len;
    logic [67:0]              prod;
    logic                     proceed;
    logic [RES_CNT_BITS-1:0]  n;
    result_t [MAX_RESULTS-1:0] rslot;

    // Offset to range field: zero extend or truncate to the field width.
    function automatic logic [RANGE_BITS-1:0] range_field(input offset_t o);
        logic [63:0] wide;
        wide = 64'(o);
        return wide[RANGE_BITS-1:0];
    endfunction

    function automatic result_t make_result(input logic [3:0] kind,
                                            input offset_t from,
                                            input offset_t upto,
                                            input logic [63:0] val,
                                            input logic [7:0] sym,
                                            input logic [2:0] blen);
        result_t r;
        r.kind_code     = kind;
        r.range_start   = range_field(from);
        r.range_end     = range_field(upto);
        r.integer_value = val;
        r.symbol_char   = sym;
        r.bad_length    = blen;
        r.run_end       = 1'b0;
        return r;
    endfunction

    // Token kind of a one-byte symbol, or TK_BAD when the byte is none.
    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h2B: k = TK_PLUS;   // '+'
            8'h2D: k = TK_MINUS;  // '-'
            8'h2A: k = TK_MUL;    // '*'
            8'h2F: k = TK_DIV;    // '/'
            8'h28: k = TK_OPEN;   // '('
            8'h29: k = TK_CLOSE;  // ')'
            8'h3D: k = TK_EQUALS; // '='
            default: k = TK_BAD;
        endcase
        return k;
    endfunction

    // Expected UTF-8 sequence length for a lead byte; 1 for anything else.
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if ((c & 8'he0) == 8'hc0) begin
            len = 3'd2;
        end else if ((c & 8'hf0) == 8'he0) begin
            len = 3'd3;
        end else if ((c & 8'hF8) == 8'hf0) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // The front takes a byte whenever the queue has room for its bundle.
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // Byte classes.
    assign b        = s_data.source_byte;
    assign off      = byte_offset_reg;
    assign off_plus = byte_offset_reg + offset_t'(1);
    assign b_digit  = (b >= 8'h30) && (b <= 8'h39);
    assign b_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    assign b_space  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
                      (b == 8'h0B) || (b == 8'h0C);
    assign b_cont   = (b & 8'hc0) == 8'h80;
    assign sym_kind = symbol_kind(b);
    assign lead_len = lead_length(b);

    // Next decimal value: acc * 10 + digit, with the carry-out marking overflow.
    assign prod = (68'(acc_reg) << 3) + (68'(acc_reg) << 1) + 68'(b[3:0]);

    // Tokenizer step for one byte.
    always_comb begin
        st_next          = st_reg;
        token_begin_next = token_begin_reg;
        byte_offset_next = byte_offset_reg;
        acc_next         = acc_reg;
        ovf_next         = ovf_reg;
        skip_rem_next    = skip_rem_reg;
        bad_begin_next   = bad_begin_reg;
        bad_count_next   = bad_count_reg;
        rslot            = '0;
        n                = '0;
        proceed          = 1'b1;

        // Continue or close the token that is open.
        case (st_reg)
            ST_SKIP: begin
                if (b_cont && skip_rem_reg != 2'd0) begin
                    bad_count_next = bad_count_reg + 3'd1;
                    skip_rem_next  = skip_rem_reg - 2'd1;
                    if (skip_rem_next == 2'd0) begin
                        rslot[n] = make_result(TK_BAD, bad_begin_reg,
                                               bad_begin_reg + offset_t'(bad_count_next),
                                               64'd0, 8'd0, bad_count_next);
                        n = n + 1'b1;
                        st_next = ST_EMPTY;
                    end
                    proceed = 1'b0;
                end else begin
                    rslot[n] = make_result(TK_BAD, bad_begin_reg,
                                           bad_begin_reg + offset_t'(bad_count_reg),
                                           64'd0, 8'd0, bad_count_reg);
                    n = n + 1'b1;
                    st_next       = ST_EMPTY;
                    skip_rem_next = 2'd0;
                end
            end
            ST_INT: begin
                if (b_digit) begin
                    if (prod[67:64] != 4'd0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[63:0];
                    end
                    proceed = 1'b0;
                end else begin
                    if (ovf_reg) begin
                        rslot[n] = make_result(TK_TOO_BIG, token_begin_reg, off,
                                               64'd0, 8'd0, 3'd0);
                    end else begin
                        rslot[n] = make_result(TK_INT, token_begin_reg, off,
                                               acc_reg, 8'd0, 3'd0);
                    end
                    n = n + 1'b1;
                    st_next = ST_EMPTY;
                end
            end
            ST_IDENT: begin
                if (b_letter || b_digit || b == 8'h5F) begin
                    proceed = 1'b0;
                end else begin
                    rslot[n] = make_result(TK_IDENT, token_begin_reg, off,
                                           64'd0, 8'd0, 3'd0);
                    n = n + 1'b1;
                    st_next = ST_EMPTY;
                end
            end
            default: begin
                st_next = ST_EMPTY;
            end
        endcase

        // Start whatever the byte begins.
        if (proceed && !b_space) begin
            if (b_digit) begin
                st_next          = ST_INT;
                token_begin_next = off;
                acc_next         = 64'(b[3:0]);
                ovf_next         = 1'b0;
            end else if (b_letter) begin
                st_next          = ST_IDENT;
                token_begin_next = off;
            end else if (sym_kind != TK_BAD) begin
                rslot[n] = make_result(sym_kind, off, off_plus, 64'd0, b, 3'd0);
                n = n + 1'b1;
            end else begin
                bad_begin_next = off;
                bad_count_next = 3'd1;
                if (lead_len == 3'd1) begin
                    rslot[n] = make_result(TK_BAD, off, off_plus, 64'd0, 8'd0, 3'd1);
                    n = n + 1'b1;
                end else begin
                    skip_rem_next = 2'(lead_len - 3'd1);
                    st_next       = ST_SKIP;
                end
            end
        end

        // The final byte flushes the open token, ends the text and restarts.
        if (s_data.final_byte) begin
            case (st_next)
                ST_INT: begin
                    if (ovf_next) begin
                        rslot[n] = make_result(TK_TOO_BIG, token_begin_next, off_plus,
                                               64'd0, 8'd0, 3'd0);
                    end else begin
                        rslot[n] = make_result(TK_INT, token_begin_next, off_plus,
                                               acc_next, 8'd0, 3'd0);
                    end
                    n = n + 1'b1;
                end
                ST_IDENT: begin
                    rslot[n] = make_result(TK_IDENT, token_begin_next, off_plus,
                                           64'd0, 8'd0, 3'd0);
                    n = n + 1'b1;
                end
                ST_SKIP: begin
                    rslot[n] = make_result(TK_BAD, bad_begin_next,
                                           bad_begin_next + offset_t'(bad_count_next),
                                           64'd0, 8'd0, bad_count_next);
                    n = n + 1'b1;
                end
                default: begin
                end
            endcase
            rslot[n] = make_result(TK_END, off_plus, off_plus, 64'd0, 8'd0, 3'd0);
            n = n + 1'b1;

            st_next          = ST_EMPTY;
            token_begin_next = '0;
            byte_offset_next = '0;
            acc_next         = '0;
            ovf_next         = 1'b0;
            skip_rem_next    = 2'd0;
            bad_begin_next   = '0;
            bad_count_next   = 3'd0;
        end else begin
            byte_offset_next = off_plus;
        end
    end

    // Only bytes that cause results take a queue entry.
    assign push              = accept && (n != '0);
    assign push_bundle.count = n;
    assign push_bundle.slot  = rslot;

    // Scanner state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= ST_EMPTY;
            token_begin_reg <= '0;
            byte_offset_reg <= '0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            skip_rem_reg    <= 2'd0;
            bad_begin_reg   <= '0;
            bad_count_reg   <= 3'd0;
        end else if (accept) begin
            st_reg          <= st_next;
            token_begin_reg <= token_begin_next;
            byte_offset_reg <= byte_offset_next;
            acc_reg         <= acc_next;
            ovf_reg         <= ovf_next;
            skip_rem_reg    <= skip_rem_next;
            bad_begin_reg   <= bad_begin_next;
            bad_count_reg   <= bad_count_next;
        end
    end

    // While skipping, at least one continuation byte is still expected.
    a_skip_has_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SKIP) |-> (skip_rem_reg != 2'd0))
        else $error("skip state with no continuation bytes left");

    // A bad character never covers more than four bytes.
    a_bad_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (bad_count_reg <= 3'd4))
        else $error("bad character count above four");

endmodule

`default_nettype wire

// File: rtl/etsc_queue.sv
// ============================================================================
// Expression token scanner bundle queue
// Short register queue of result bundles between the front and the back.
// ============================================================================
`default_nettype none

module etsc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire etsc_pkg::bundle_t push_bundle,
    input  wire logic              pop,
    output etsc_pkg::bundle_t      head,
    output etsc_pkg::q_status_t    q_status
);
    import etsc_pkg::*;

    bundle_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/etsc_back.sv
// ============================================================================
// Expression token scanner back end
// Takes bundles from the queue head and hands their results out one per
// cycle through an output register while not stalled, marking the last result of each byte.
// ============================================================================
`default_nettype none

module etsc_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire etsc_pkg::bundle_t   head,
    input  wire etsc_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output etsc_pkg::result_t        m_data
);
    import etsc_pkg::*;

    logic                    m_valid_reg, m_valid_next;
    result_t                 m_data_reg;
    logic [RES_IDX_BITS-1:0] idx_reg, idx_next;
    logic                    load;
    logic                    last;
    result_t                 picked;

    // Load a new result when the output register is free or being drained.
    assign load = (!m_valid_reg || m_ready) && !q_status.empty;
    assign last = (RES_CNT_BITS'(idx_reg) == head.count - 1'b1);
    assign pop  = load && last;

    always_comb begin
        picked         = head.slot[idx_reg];
        picked.run_end = last;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = last ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    // Output payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= picked;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // While the queue holds a bundle, the result index points inside the head bundle.
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_status.empty |-> (RES_CNT_BITS'(idx_reg) < head.count))
        else $error("result index beyond the head bundle");

    // Between bundles the index is back at the first slot.
    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == '0))
        else $error("result index not restarted after a bundle");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Expression token scanner testbench
// Feeds source bytes as requests, both hand-picked texts and random texts
// built from tokens, and predicts every token with a software copy of the
// scanner. Each token leaving the block is compared field by field with the
// oldest prediction while both channels idle and stall at random.
// ============================================================================

module tb_top;

    import etsc_pkg::*;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int DIRECTED_BYTES = 27;
    localparam int RANDOM_BYTES   = 75;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 16;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_NAME,
        SCAN_SKIP
    } scan_mode_e;

    // Software copy of the scanner plus the queue of tokens still awaited.
    class token_scoreboard;
        scan_mode_e  mode;
        offset_t     cur_offset;
        offset_t     tok_begin;
        offset_t     bad_from;
        logic [63:0] number;
        logic        too_big;
        logic [1:0]  cont_left;
        logic [2:0]  bad_len;
        result_t     burst[$];
        result_t     expected_tokens[$];
        int unsigned failures;

        function new();
            clear_scan();
            failures = 0;
        endfunction

        function void clear_scan();
            mode       = SCAN_IDLE;
            cur_offset = '0;
            tok_begin  = '0;
            bad_from   = '0;
            number     = '0;
            too_big    = 1'b0;
            cont_left  = '0;
            bad_len    = '0;
        endfunction

        function int expected_count();
            return expected_tokens.size();
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_letter(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit is_space(logic [7:0] b);
            return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D ||
                   b == 8'h0B || b == 8'h0C;
        endfunction

        function logic [3:0] symbol_kind(logic [7:0] b);
            case (b)
                "+": return TK_PLUS;
                "-": return TK_MINUS;
                "*": return TK_MUL;
                "/": return TK_DIV;
                "(": return TK_OPEN;
                ")": return TK_CLOSE;
                "=": return TK_EQUALS;
                default: return TK_BAD;
            endcase
        endfunction

        function void add_token(logic [3:0] kind, offset_t from, offset_t to,
                                logic [63:0] value, logic [7:0] sym,
                                logic [2:0] blen);
            result_t tok;
            tok.kind_code     = kind;
            tok.range_start   = from;
            tok.range_end     = to;
            tok.integer_value = value;
            tok.symbol_char   = sym;
            tok.bad_length    = blen;
            tok.run_end       = 1'b0;
            burst.push_back(tok);
        endfunction

        function void close_number(offset_t to);
            if (too_big) begin
                add_token(TK_TOO_BIG, tok_begin, to, '0, '0, '0);
            end else begin
                add_token(TK_INT, tok_begin, to, number, '0, '0);
            end
        endfunction

        function void close_bad();
            add_token(TK_BAD, bad_from, bad_from + bad_len, '0, '0, bad_len);
        endfunction

        // Advance the scanner by one byte found at offset at.
        function void scan(logic [7:0] b, offset_t at);
            offset_t     after;
            logic [63:0] digit;
            logic [3:0]  kind;
            after = at + 1;
            // First let the open token take the byte or close it.
            case (mode)
                SCAN_SKIP: begin
                    if (b[7:6] == 2'b10 && cont_left != 0) begin
                        bad_len++;
                        cont_left--;
                        if (cont_left == 0) begin
                            close_bad();
                            mode = SCAN_IDLE;
                        end
                        return;
                    end
                    close_bad();
                    mode = SCAN_IDLE;
                    cont_left = '0;
                end
                SCAN_NUMBER: begin
                    if (is_digit(b)) begin
                        digit = 64'(b - "0");
                        if (number > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 10) begin
                            too_big = 1'b1;
                        end else begin
                            number = number * 10 + digit;
                        end
                        return;
                    end
                    close_number(at);
                    mode = SCAN_IDLE;
                end
                SCAN_NAME: begin
                    if (is_letter(b) || is_digit(b) || b == "_") return;
                    add_token(TK_IDENT, tok_begin, at, '0, '0, '0);
                    mode = SCAN_IDLE;
                end
                default: ;
            endcase

            // The byte now starts whatever comes next.
            if (is_space(b)) return;
            if (is_digit(b)) begin
                mode      = SCAN_NUMBER;
                tok_begin = at;
                number    = 64'(b - "0");
                too_big   = 1'b0;
                return;
            end
            if (is_letter(b)) begin
                mode      = SCAN_NAME;
                tok_begin = at;
                return;
            end
            kind = symbol_kind(b);
            if (kind != TK_BAD) begin
                add_token(kind, at, after, '0, b, '0);
                return;
            end
            // Bad character: a multi-byte lead waits for its continuations.
            bad_from = at;
            bad_len  = 3'd1;
            if ((b & 8'hE0) == 8'hC0) begin
                cont_left = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                cont_left = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                cont_left = 2'd3;
            end else begin
                close_bad();
                return;
            end
            mode = SCAN_SKIP;
        endfunction

        // Predict the tokens caused by one accepted request.
        function void note_request(request_t req);
            offset_t after;
            result_t tok;
            int      i;
            burst.delete();
            after = cur_offset + 1;
            scan(req.source_byte, cur_offset);
            if (req.final_byte) begin
                case (mode)
                    SCAN_NUMBER: close_number(after);
                    SCAN_NAME:   add_token(TK_IDENT, tok_begin, after, '0, '0, '0);
                    SCAN_SKIP:   close_bad();
                    default: ;
                endcase
                add_token(TK_END, after, after, '0, '0, '0);
                clear_scan();
            end else begin
                cur_offset = after;
            end
            for (i = 0; i < burst.size(); i++) begin
                tok = burst[i];
                tok.run_end = (i == burst.size() - 1);
                expected_tokens.push_back(tok);
            end
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // Compare one token from the block with the oldest prediction.
        function void check_result(result_t got);
            result_t want;
            bit      ok;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual %0h",
                         $time, got);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            ok = 1'b1;
            ok &= field_ok("kind_code", want.kind_code, got.kind_code);
            ok &= field_ok("range_start", want.range_start, got.range_start);
            ok &= field_ok("range_end", want.range_end, got.range_end);
            ok &= field_ok("integer_value", want.integer_value, got.integer_value);
            ok &= field_ok("symbol_char", want.symbol_char, got.symbol_char);
            ok &= field_ok("bad_length", want.bad_length, got.bad_length);
            ok &= field_ok("run_end", want.run_end, got.run_end);
            if (!ok) failures++;
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    request_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    result_t  m_data;

    token_scoreboard sb;
    int unsigned     idle_pct    = 0;
    int unsigned     stall_pct   = 0;
    int unsigned     bytes_sent  = 0;
    int unsigned     quiet_count = 0;
    logic [7:0]      text_bytes[$];

    logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
    string      operators      = "+-*/()=";
    string      wide_numbers[5] = '{"18446744073709551615", "18446744073709551616",
                                    "99999999999999999999", "1844674407370955161",
                                    "000000000000000000000000042"};

    expression_token_scanner_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Token checking and the no-progress watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Idling phases follow the progress through the stimulus.
    task automatic pick_phase();
        int phase;
        phase = (bytes_sent * 4) / (DIRECTED_BYTES + RANDOM_BYTES);
        case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 59; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 26; stall_pct = 26; end
        endcase
    endtask

    // Offer one request and wait until the block takes it.
    task automatic send_request(input request_t req);
        @(negedge aclk);
        pick_phase();
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        bytes_sent++;
    endtask

    // Send the collected text, marking its last byte as final.
    task automatic send_text();
        request_t req;
        int       i;
        for (i = 0; i < text_bytes.size(); i++) begin
            req.source_byte = text_bytes[i];
            req.final_byte  = (i == text_bytes.size() - 1);
            send_request(req);
        end
        text_bytes.delete();
    endtask

    task automatic push_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int idx;
        idx = $urandom_range(0, 51);
        return (idx < 26) ? 8'("a" + idx) : 8'("A" + idx - 26);
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Append one random token, mostly well formed, sometimes noise.
    task automatic add_random_piece();
        int         pick;
        int         len;
        int         conts;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            text_bytes.push_back(random_letter());
            len = $urandom_range(0, 5);
            repeat (len) begin
                case ($urandom_range(0, 2))
                    0:       text_bytes.push_back(random_letter());
                    1:       text_bytes.push_back(random_digit());
                    default: text_bytes.push_back("_");
                endcase
            end
        end else if (pick < 40) begin
            len = $urandom_range(1, 5);
            repeat (len) text_bytes.push_back(random_digit());
        end else if (pick < 48) begin
            // Numbers around the 64-bit limit.
            if ($urandom_range(0, 1) == 0) begin
                push_string(wide_numbers[$urandom_range(0, 4)]);
            end else begin
                len = $urandom_range(19, 23);
                repeat (len) text_bytes.push_back(random_digit());
            end
        end else if (pick < 66) begin
            text_bytes.push_back(operators[$urandom_range(0, 6)]);
        end else if (pick < 76) begin
            text_bytes.push_back(blank_chars[$urandom_range(0, 5)]);
        end else if (pick < 90) begin
            // Multi-byte sequence, usually complete, sometimes cut short.
            len = $urandom_range(2, 4);
            lead = 8'($urandom_range(0, 255));
            case (len)
                2:       lead = {3'b110, lead[4:0]};
                3:       lead = {4'b1110, lead[3:0]};
                default: lead = {5'b11110, lead[2:0]};
            endcase
            text_bytes.push_back(lead);
            conts = ($urandom_range(0, 3) != 0) ? len - 1 : $urandom_range(0, len - 1);
            repeat (conts) text_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
        end else begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) begin
            text_bytes.push_back(blank_chars[$urandom_range(0, 5)]);
        end
    endtask

    initial begin
        int pieces;
        sb = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Every symbol, then a name flushed by the final byte.
        push_string("+-*/()= Az_9");
        send_text();
        // NUL, leading underscore, complete and cut multi-byte sequences,
        // an invalid lead, then a number flushed by the final byte.
        text_bytes = '{8'h00, "_", 8'hC3, 8'hA9, 8'hE2, 8'h82, "!", 8'hF0,
                       8'h9F, 8'h98, 8'h80, 8'hFF, 8'h09, "7"};
        send_text();
        // A lone lead byte that is also the final byte.
        text_bytes = '{8'hE2};
        send_text();

        while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
            pieces = $urandom_range(1, 6);
            repeat (pieces) add_random_piece();
            send_text();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.expected_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.expected_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: expression_token_scanner_top.f
rtl/etsc_pkg.sv
rtl/etsc_front.sv
rtl/etsc_queue.sv
rtl/etsc_back.sv
rtl/expression_token_scanner_top.sv
sim/tb_top.sv
